// ===== sv/karf_pkg.sv =====
package karf_pkg;

    // Register indexes of the configuration port.
    localparam logic [1:0] REG_NOISE_VALUE = 2'd0;
    localparam logic [1:0] REG_NOISE_BIAS  = 2'd1;
    localparam logic [1:0] REG_NOISE_MEAS  = 2'd2;

    // Reset values of the noise registers, unsigned Q0.24.
    localparam logic [23:0] RESET_NOISE_VALUE = 24'd83886;
    localparam logic [23:0] RESET_NOISE_BIAS  = 24'd50332;
    localparam logic [23:0] RESET_NOISE_MEAS  = 24'd503316;

    // Step time to seconds: step * 2^16 / 1000 equals step * 8192 / 125, and
    // 8192 = 65 * 125 + 67, so the quotient is step * 65 + (step * 67) / 125.
    localparam logic [6:0] DT_WHOLE_MUL = 7'd65;
    localparam logic [6:0] DT_PART_MUL  = 7'd67;

    // Reciprocal of 125, ceil(2^38 / 125); exact for dividends below 2^31.
    localparam logic [31:0] DT_RECIP       = 32'd2199023256;
    localparam int          DT_RECIP_SHIFT = 38;

    // The shared divider works through this many dividend bits.
    localparam int DIV_BITS = 56;

    // Saturate a wide signed value to signed 32 bits.
    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sh0000_0000_7FFF_FFFF)
        begin
            r = 32'sh7FFF_FFFF;
        end
        else if (v < -64'sh0000_0000_8000_0000)
        begin
            r = 32'sh8000_0000;
        end
        else
        begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

// ===== sv/kalman_angle_rate_filter.sv =====
// Channel  Direction  Signals
// in       input      in_valid, in_ready, measured_value, measured_rate, step_time_ms
// out      output     out_valid, out_ready, filtered_value
// cfg      input      cfg_valid, cfg_ready, cfg_index, cfg_data
//
// One shared 35x35 multiplier serves the step time reciprocal and eleven filter
// products, each multiplied and then accumulated, and a 56-step shared restoring
// divider forms each of the two gains. When S is not positive the divisions are
// skipped.
// The block accepts an item only while its sequencer is idle.
// A finished result waits in the output register; a new item may be taken meanwhile.
// Reset (rst_n low) clears the filter state and restores the default noise values.
module kalman_angle_rate_filter
    import karf_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [31:0] measured_value,
    input  logic signed [31:0] measured_rate,
    input  logic [23:0]        step_time_ms,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] filtered_value,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [23:0]        cfg_data
);

    typedef enum logic [2:0] {S_IDLE, S_DT, S_DTSET, S_DIV, S_MUL, S_ACC, S_CORR,
                              S_DONE} state_t;
    typedef enum logic {DIV_K0, DIV_K1} div_sel_t;

    localparam logic [5:0] DIV_LAST = 6'(DIV_BITS - 1);
    localparam logic [3:0] OP_LAST_PREDICT = 4'd4;
    localparam logic [3:0] OP_FIRST_CORRECT = 4'd5;
    localparam logic [3:0] OP_LAST = 4'd10;

    state_t state_reg;
    div_sel_t div_sel_reg;
    logic [3:0] op_reg;
    logic [5:0] div_cnt_reg;
    logic [32:0] rem_reg;
    logic [DIV_BITS-1:0] dvd_reg;
    logic [32:0] divisor_reg;
    logic div_neg_reg;

    logic [23:0] noise_value_reg, noise_bias_reg, noise_meas_reg;
    logic signed [31:0] estimate_reg, bias_reg;
    logic signed [31:0] cov00_reg, cov01_reg, cov10_reg, cov11_reg;
    logic signed [31:0] p00_reg, p01_reg, p10_reg, p11_reg;
    logic signed [31:0] k0_reg, k1_reg;
    logic signed [31:0] z_reg, rate_reg;
    logic [23:0] step_reg;
    logic [31:0] dt_reg;
    logic signed [32:0] y_reg;
    logic signed [69:0] prod_reg;
    logic out_valid_reg;
    logic signed [31:0] out_value_reg;

    assign in_ready = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign filtered_value = out_value_reg;

    // Divider step: shift in one dividend bit and try to subtract.
    logic [33:0] rem_sh;
    logic q_bit;
    logic [32:0] rem_next;
    logic [DIV_BITS-1:0] dvd_next;
    logic signed [63:0] quo_signed;
    logic signed [31:0] gain_next;

    always_comb
    begin
        rem_sh = {rem_reg, dvd_reg[DIV_BITS-1]};
        q_bit = (rem_sh >= {1'b0, divisor_reg});
        rem_next = q_bit ? 33'(rem_sh - {1'b0, divisor_reg}) : rem_sh[32:0];
        dvd_next = {dvd_reg[DIV_BITS-2:0], q_bit};
        quo_signed = div_neg_reg ? -$signed({8'b0, dvd_next}) : $signed({8'b0, dvd_next});
        gain_next = sat32(quo_signed);
    end

    // Constant multiples of the step time for the conversion to seconds.
    logic [30:0] step_whole, step_part;

    always_comb
    begin
        step_whole = 31'(step_reg) * 31'(DT_WHOLE_MUL);
        step_part = 31'(step_reg) * 31'(DT_PART_MUL);
    end

    // Operand selection for the shared multiplier.
    logic signed [34:0] mul_a, mul_b;
    logic signed [31:0] acc_base;
    logic acc_sub, acc_dt;
    logic signed [34:0] dt_ext;

    always_comb
    begin
        dt_ext = $signed({3'b0, dt_reg});
        mul_a = '0;
        mul_b = '0;
        acc_base = '0;
        acc_sub = 1'b0;
        acc_dt = 1'b0;
        if (state_reg == S_DT)
        begin
            mul_a = $signed({4'b0, step_part});
            mul_b = $signed({3'b0, DT_RECIP});
        end
        else
        begin
            unique case (op_reg)
                4'd0:
                begin
                    mul_a = 35'(rate_reg) - 35'(bias_reg);
                    mul_b = dt_ext;
                    acc_base = estimate_reg;
                    acc_dt = 1'b1;
                end
                4'd1:
                begin
                    mul_a = 35'(cov11_reg);
                    mul_b = dt_ext;
                    acc_base = cov01_reg;
                    acc_sub = 1'b1;
                    acc_dt = 1'b1;
                end
                4'd2:
                begin
                    mul_a = 35'(cov11_reg);
                    mul_b = dt_ext;
                    acc_base = cov10_reg;
                    acc_sub = 1'b1;
                    acc_dt = 1'b1;
                end
                4'd3:
                begin
                    mul_a = $signed({11'b0, noise_value_reg}) - 35'(cov10_reg)
                            - 35'(cov01_reg);
                    mul_b = dt_ext;
                    acc_base = cov00_reg;
                    acc_dt = 1'b1;
                end
                4'd4:
                begin
                    mul_a = $signed({11'b0, noise_bias_reg});
                    mul_b = dt_ext;
                    acc_base = cov11_reg;
                    acc_dt = 1'b1;
                end
                4'd5:
                begin
                    mul_a = 35'(k0_reg);
                    mul_b = 35'(y_reg);
                    acc_base = estimate_reg;
                end
                4'd6:
                begin
                    mul_a = 35'(k1_reg);
                    mul_b = 35'(y_reg);
                    acc_base = bias_reg;
                end
                4'd7:
                begin
                    mul_a = 35'(k0_reg);
                    mul_b = 35'(p00_reg);
                    acc_base = p00_reg;
                    acc_sub = 1'b1;
                end
                4'd8:
                begin
                    mul_a = 35'(k0_reg);
                    mul_b = 35'(p01_reg);
                    acc_base = p01_reg;
                    acc_sub = 1'b1;
                end
                4'd9:
                begin
                    mul_a = 35'(k1_reg);
                    mul_b = 35'(p00_reg);
                    acc_base = p10_reg;
                    acc_sub = 1'b1;
                end
                default:
                begin
                    mul_a = 35'(k1_reg);
                    mul_b = 35'(p01_reg);
                    acc_base = p11_reg;
                    acc_sub = 1'b1;
                end
            endcase
        end
    end

    // Round half up, shift out the fraction, add to or subtract from the base and saturate.
    logic signed [69:0] prod_rnd, prod_shift;
    logic signed [63:0] acc_sum;
    logic signed [31:0] acc_result;

    always_comb
    begin
        prod_rnd = prod_reg + (acc_dt ? (70'sd1 <<< 31) : (70'sd1 <<< 23));
        prod_shift = acc_dt ? (prod_rnd >>> 32) : (prod_rnd >>> 24);
        acc_sum = acc_sub ? (64'(acc_base) - prod_shift[63:0])
                          : (64'(acc_base) + prod_shift[63:0]);
        acc_result = sat32(acc_sum);
    end

    // Correction setup: S and magnitudes of the gain numerators.
    logic signed [32:0] s_sum;
    logic [31:0] p00_mag, p10_mag;

    always_comb
    begin
        s_sum = 33'(p00_reg) + $signed({9'b0, noise_meas_reg});
        p00_mag = p00_reg[31] ? 32'(-p00_reg) : 32'(p00_reg);
        p10_mag = p10_reg[31] ? 32'(-p10_reg) : 32'(p10_reg);
    end

    // Sequencer, state and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            div_sel_reg <= DIV_K0;
            op_reg <= '0;
            div_cnt_reg <= '0;
            noise_value_reg <= RESET_NOISE_VALUE;
            noise_bias_reg <= RESET_NOISE_BIAS;
            noise_meas_reg <= RESET_NOISE_MEAS;
            estimate_reg <= '0;
            bias_reg <= '0;
            cov00_reg <= '0;
            cov01_reg <= '0;
            cov10_reg <= '0;
            cov11_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // Configuration writes.
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    REG_NOISE_VALUE: noise_value_reg <= cfg_data;
                    REG_NOISE_BIAS:  noise_bias_reg <= cfg_data;
                    REG_NOISE_MEAS:  noise_meas_reg <= cfg_data;
                    default: ;
                endcase
            end

            // The final state reloads the output register itself.
            if (out_valid_reg && out_ready && (state_reg != S_DONE))
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        z_reg <= measured_value;
                        rate_reg <= measured_rate;
                        step_reg <= step_time_ms;
                        state_reg <= S_DT;
                    end
                end
                S_DT:
                begin
                    prod_reg <= mul_a * mul_b;
                    state_reg <= S_DTSET;
                end
                S_DTSET:
                begin
                    dt_reg <= {1'b0, step_whole}
                              + prod_reg[DT_RECIP_SHIFT+31:DT_RECIP_SHIFT];
                    op_reg <= '0;
                    state_reg <= S_MUL;
                end
                S_DIV:
                begin
                    if (div_cnt_reg == DIV_LAST)
                    begin
                        div_cnt_reg <= '0;
                        rem_reg <= '0;
                        unique case (div_sel_reg)
                            DIV_K0:
                            begin
                                k0_reg <= gain_next;
                                dvd_reg <= {p10_mag, 24'b0};
                                div_neg_reg <= p10_reg[31];
                                div_sel_reg <= DIV_K1;
                            end
                            default:
                            begin
                                k1_reg <= gain_next;
                                op_reg <= OP_FIRST_CORRECT;
                                state_reg <= S_MUL;
                            end
                        endcase
                    end
                    else
                    begin
                        rem_reg <= rem_next;
                        dvd_reg <= dvd_next;
                        div_cnt_reg <= div_cnt_reg + 6'd1;
                    end
                end
                S_MUL:
                begin
                    prod_reg <= mul_a * mul_b;
                    state_reg <= S_ACC;
                end
                S_ACC:
                begin
                    unique case (op_reg)
                        4'd0: estimate_reg <= acc_result;
                        4'd1: p01_reg <= acc_result;
                        4'd2: p10_reg <= acc_result;
                        4'd3: p00_reg <= acc_result;
                        4'd4: p11_reg <= acc_result;
                        4'd5: estimate_reg <= acc_result;
                        4'd6: bias_reg <= acc_result;
                        4'd7: cov00_reg <= acc_result;
                        4'd8: cov01_reg <= acc_result;
                        4'd9: cov10_reg <= acc_result;
                        default: cov11_reg <= acc_result;
                    endcase
                    op_reg <= op_reg + 4'd1;
                    priority if (op_reg == OP_LAST_PREDICT)
                    begin
                        state_reg <= S_CORR;
                    end
                    else if (op_reg == OP_LAST)
                    begin
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        state_reg <= S_MUL;
                    end
                end
                S_CORR:
                begin
                    y_reg <= 33'(z_reg) - 33'(estimate_reg);
                    if (s_sum > 33'sd0)
                    begin
                        divisor_reg <= s_sum;
                        dvd_reg <= {p00_mag, 24'b0};
                        div_neg_reg <= p00_reg[31];
                        rem_reg <= '0;
                        div_cnt_reg <= '0;
                        div_sel_reg <= DIV_K0;
                        state_reg <= S_DIV;
                    end
                    else
                    begin
                        k0_reg <= '0;
                        k1_reg <= '0;
                        op_reg <= OP_FIRST_CORRECT;
                        state_reg <= S_MUL;
                    end
                end
                default:
                begin
                    // Hand the result over once the output register is free.
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg <= 1'b1;
                        out_value_reg <= estimate_reg;
                        state_reg <= S_IDLE;
                    end
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    // The divider remainder stays below the divisor.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (rem_reg < divisor_reg))
        else $error("divider remainder not below divisor");

    // An accepted item starts with the step time conversion.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == S_DT))
        else $error("accepted item did not start the step time conversion");

    // Every accumulate follows a multiply.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ACC) |-> ($past(state_reg) == S_MUL))
        else $error("accumulate without a preceding multiply");
`endif

endmodule

// ===== sim/tb.sv =====
module tb;
    import karf_pkg::*;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic signed [31:0] measured_value;
    logic signed [31:0] measured_rate;
    logic [23:0]        step_time_ms;
    logic               out_valid;
    logic               out_ready;
    logic signed [31:0] filtered_value;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [1:0]         cfg_index;
    logic [23:0]        cfg_data;

    typedef struct packed {
        logic signed [31:0] value;
        logic signed [31:0] rate;
        logic [23:0]        step;
    } sample_t;

    // Filter state as the checker tracks it.
    logic [23:0]        q_value;
    logic [23:0]        q_bias;
    logic [23:0]        r_meas;
    logic signed [31:0] est;
    logic signed [31:0] bias;
    logic signed [31:0] p00_s;
    logic signed [31:0] p01_s;
    logic signed [31:0] p10_s;
    logic signed [31:0] p11_s;

    sample_t            pending_samples[$];
    logic signed [31:0] expected_values[$];
    int                 error_count;
    int                 in_wait;
    int                 out_wait;
    bit                 hold_sender;

    kalman_angle_rate_filter u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .measured_value (measured_value),
        .measured_rate  (measured_rate),
        .step_time_ms   (step_time_ms),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .filtered_value (filtered_value),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    function automatic logic signed [31:0] clamp32(input logic signed [127:0] v);
        if (v > 128'sh7FFF_FFFF)
        begin
            return 32'sh7FFF_FFFF;
        end
        else if (v < -128'sh8000_0000)
        begin
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

    // Rounding half up: add half an LSB, then an arithmetic shift floors.
    function automatic logic signed [127:0] round_down(input logic signed [127:0] x,
                                                       input int s);
        logic signed [127:0] one;
        one = 128'sd1;
        return (x + (one <<< (s - 1))) >>> s;
    endfunction

    function automatic logic signed [31:0] gain_of(input logic signed [31:0] p,
                                                   input logic signed [127:0] s);
        logic signed [127:0] num;
        num = 128'(p) * 128'sd16777216;
        return clamp32(num / s);
    endfunction

    // Advance the tracked filter by one sample and return its new estimate.
    function automatic logic signed [31:0] filter_step(input sample_t smp);
        logic signed [127:0] dt;
        logic signed [127:0] dp;
        logic signed [127:0] y;
        logic signed [127:0] s;
        logic signed [31:0]  a00;
        logic signed [31:0]  a01;
        logic signed [31:0]  a10;
        logic signed [31:0]  a11;
        logic signed [31:0]  k0;
        logic signed [31:0]  k1;
        dt = ({104'd0, smp.step} << 16) / 128'sd1000;
        est = clamp32(128'(est) + round_down((128'(smp.rate) - 128'(bias)) * dt, 32));
        dp = round_down(128'(p11_s) * dt, 32);
        a00 = clamp32(128'(p00_s) + round_down((128'($signed({1'b0, q_value}))
                      - 128'(p10_s) - 128'(p01_s)) * dt, 32));
        a01 = clamp32(128'(p01_s) - dp);
        a10 = clamp32(128'(p10_s) - dp);
        a11 = clamp32(128'(p11_s) + round_down(128'($signed({1'b0, q_bias})) * dt, 32));
        y = 128'(smp.value) - 128'(est);
        s = 128'(a00) + 128'($signed({1'b0, r_meas}));
        k0 = 32'sd0;
        k1 = 32'sd0;
        // A non-positive innovation variance skips the correction.
        if (s > 0)
        begin
            k0 = gain_of(a00, s);
            k1 = gain_of(a10, s);
        end
        est   = clamp32(128'(est) + round_down(128'(k0) * y, 24));
        bias  = clamp32(128'(bias) + round_down(128'(k1) * y, 24));
        p00_s = clamp32(128'(a00) - round_down(128'(k0) * 128'(a00), 24));
        p01_s = clamp32(128'(a01) - round_down(128'(k0) * 128'(a01), 24));
        p10_s = clamp32(128'(a10) - round_down(128'(k1) * 128'(a00), 24));
        p11_s = clamp32(128'(a11) - round_down(128'(k1) * 128'(a01), 24));
        return est;
    endfunction

    function automatic sample_t random_sample();
        sample_t smp;
        smp.value = $urandom;
        smp.rate  = $urandom;
        smp.step  = 24'($urandom);
        case ($urandom_range(0, 3))
            0:
            begin
                smp.value = $signed($urandom_range(0, 200000)) - 100000;
                smp.rate  = $signed($urandom_range(0, 2000000)) - 1000000;
                smp.step  = 24'($urandom_range(0, 2000000));
            end
            1: smp.step = 24'($urandom_range(0, 65536 * 20));
            default: ;
        endcase
        return smp;
    endfunction

    function automatic sample_t make_sample(input logic signed [31:0] v,
                                            input logic signed [31:0] r,
                                            input logic [23:0] st);
        sample_t smp;
        smp.value = v;
        smp.rate  = r;
        smp.step  = st;
        return smp;
    endfunction

    // Write one register through the configuration channel.
    task automatic write_reg(input logic [1:0] idx, input logic [23:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == REG_NOISE_VALUE)
        begin
            q_value = data;
        end
        else if (idx == REG_NOISE_BIAS)
        begin
            q_bias = data;
        end
        else if (idx == REG_NOISE_MEAS)
        begin
            r_meas = data;
        end
    endtask

    // Wait until the block has delivered every result and gone quiet.
    task automatic drain();
        while (pending_samples.size() != 0 || in_valid || expected_values.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (400) @(posedge clk);
    endtask

    task automatic send_random(input int count);
        for (int i = 0; i < count; i++)
        begin
            pending_samples.push_back(random_sample());
        end
    endtask

    // Driver: one sample per handshake, with a random gap after each.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid       <= 1'b0;
            measured_value <= '0;
            measured_rate  <= '0;
            step_time_ms   <= '0;
            in_wait        <= 0;
        end
        else if (!in_valid || in_ready)
        begin
            if (in_valid)
            begin
                expected_values.push_back(filter_step({measured_value, measured_rate,
                                                       step_time_ms}));
            end
            if (in_wait > 0)
            begin
                in_wait  <= in_wait - 1;
                in_valid <= 1'b0;
            end
            else if (pending_samples.size() != 0 && !hold_sender)
            begin
                sample_t smp;
                smp = pending_samples.pop_front();
                in_valid       <= 1'b1;
                measured_value <= smp.value;
                measured_rate  <= smp.rate;
                step_time_ms   <= smp.step;
                in_wait        <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Monitor: compare each result, with random stalls on the ready side.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            out_wait  <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_values.size() == 0)
                begin
                    $display("%0t: unexpected result filtered_value=%0d", $time,
                             filtered_value);
                    error_count++;
                end
                else
                begin
                    logic signed [31:0] exp_val;
                    exp_val = expected_values.pop_front();
                    if (exp_val !== filtered_value)
                    begin
                        $display("%0t: filtered_value expected %0d actual %0d", $time,
                                 exp_val, filtered_value);
                        error_count++;
                    end
                end
                out_wait <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
                out_ready <= 1'b0;
            end
            else if (out_wait > 0)
            begin
                out_wait  <= out_wait - 1;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    initial
    begin
        #20000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        error_count   = 0;
        hold_sender   = 1'b0;
        q_value = RESET_NOISE_VALUE;
        q_bias  = RESET_NOISE_BIAS;
        r_meas  = RESET_NOISE_MEAS;
        est = 0;
        bias = 0;
        p00_s = 0;
        p01_s = 0;
        p10_s = 0;
        p11_s = 0;
        cfg_valid <= 1'b0;
        cfg_index <= REG_NOISE_VALUE;
        cfg_data  <= '0;
        rst_n = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: default noise, field extremes, zero step time.
        pending_samples.push_back(make_sample(32'sd65536, 32'sd0, 24'd0));
        pending_samples.push_back(make_sample(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 24'hFF_FFFF));
        pending_samples.push_back(make_sample(32'sh8000_0000, 32'sh8000_0000, 24'hFF_FFFF));
        pending_samples.push_back(make_sample(32'sh7FFF_FFFF, 32'sh8000_0000, 24'd65536));
        pending_samples.push_back(make_sample(32'sh8000_0000, 32'sh7FFF_FFFF, 24'd1));
        pending_samples.push_back(make_sample(32'sd0, 32'sd0, 24'd0));
        pending_samples.push_back(make_sample(-32'sd1, -32'sd1, 24'h55_5555));
        pending_samples.push_back(make_sample(32'sh5555_5555, 32'shAAAA_AAAA, 24'hAA_AAAA));
        drain();

        // Extreme noise: huge covariance growth and the smallest R.
        write_reg(REG_NOISE_VALUE, 24'hFF_FFFF);
        write_reg(REG_NOISE_BIAS, 24'hFF_FFFF);
        write_reg(REG_NOISE_MEAS, 24'd1);
        for (int i = 0; i < 8; i++)
        begin
            pending_samples.push_back(make_sample(32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                                                  24'hFF_FFFF));
        end
        send_random(150);
        drain();

        // Zero process noise with the largest R.
        write_reg(REG_NOISE_VALUE, 24'd0);
        write_reg(REG_NOISE_BIAS, 24'd0);
        write_reg(REG_NOISE_MEAS, 24'hFF_FFFF);
        send_random(150);
        drain();

        // Random settings, with one phase where the sender holds back its queued samples.
        for (int ph = 0; ph < 4; ph++)
        begin
            write_reg(REG_NOISE_VALUE, 24'($urandom));
            write_reg(REG_NOISE_BIAS, 24'($urandom));
            write_reg(REG_NOISE_MEAS, 24'($urandom_range(1, 24'hFF_FFFF)));
            if (ph == 1)
            begin
                hold_sender = 1'b1;
                send_random(20);
                repeat (50) @(posedge clk);
                hold_sender = 1'b0;
            end
            else
            begin
                send_random(150);
            end
            drain();
        end

        // Back to defaults for the last stretch.
        write_reg(REG_NOISE_VALUE, RESET_NOISE_VALUE);
        write_reg(REG_NOISE_BIAS, RESET_NOISE_BIAS);
        write_reg(REG_NOISE_MEAS, RESET_NOISE_MEAS);
        send_random(150);
        drain();

        if (error_count == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
